// File: rtl/strip_hit_clusterer_unit_assert.svh
// assertion macros for the clusterer checker file
// depends on: nothing; users provide clk and rst_n in scope
`ifndef STRIP_HIT_CLUSTERER_UNIT_ASSERT_SVH
`define STRIP_HIT_CLUSTERER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/shc_pkg.sv
// shared types, constants and helpers for the strip hit clusterer
// depends on: nothing
package shc_pkg;

    // sizes of the hit store and of the hit fields
    localparam int MAX_HITS     = 64;
    localparam int ADC_BITS     = 12;
    localparam int CHANNEL_BITS = 10;
    localparam int IDX_W        = $clog2(MAX_HITS);
    localparam int CNT_W        = IDX_W + 1;

    // configuration register widths and indexes
    localparam int STEP_W   = 6;
    localparam int FACTOR_W = 8;
    localparam int FRAC_W   = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NB_FACTOR    = 2'd2;
    localparam logic [STEP_W-1:0]    RST_MAX_STEP     = 6'd1;
    localparam logic [FACTOR_W-1:0]  RST_SEED_FACTOR  = 8'd48;
    localparam logic [FACTOR_W-1:0]  RST_NB_FACTOR    = 8'd16;

    // derived arithmetic widths
    localparam int DMAX_W = STEP_W + 1;
    localparam int LIM_W  = DMAX_W + CNT_W;
    localparam int PROD_W = ADC_BITS + FACTOR_W;

    // stream payload layout
    localparam int HIT_W     = 2 * ADC_BITS + CHANNEL_BITS + 1;
    localparam int IN_DATA_W = ((HIT_W + 7) / 8) * 8;
    localparam int OUT_W     = 6;
    localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8;

    // one stored hit
    typedef struct packed {
        logic                    flt;
        logic [CHANNEL_BITS-1:0] chan;
        logic [ADC_BITS-1:0]     thr;
        logic [ADC_BITS-1:0]     adc;
    } hit_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_FWD_RD,
        ST_FWD_CHK,
        ST_BWD_RD,
        ST_BWD_CHK,
        ST_EMIT
    } shc_state_t;

    // adc * 16 >= factor * thr
    function automatic logic reaches(logic [ADC_BITS-1:0] adc,
                                     logic [FACTOR_W-1:0] factor,
                                     logic [ADC_BITS-1:0] thr);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        lhs = PROD_W'({adc, {FRAC_W{1'b0}}});
        rhs = PROD_W'(factor) * PROD_W'(thr);
        return lhs >= rhs;
    endfunction

    // absolute channel distance
    function automatic logic [CHANNEL_BITS-1:0] chan_dist(logic [CHANNEL_BITS-1:0] a,
                                                          logic [CHANNEL_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/shc_hit_ram.sv
// hit store: one write port, one read port with registered read data
// depends on: shc_pkg
module shc_hit_ram
    import shc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  hit_t             wdata,
    input  logic [IDX_W-1:0] raddr,
    output hit_t             rdata
);

    hit_t mem [MAX_HITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/strip_hit_clusterer_unit.sv
// strip hit clusterer: loads one event's hits, then scans them for clusters
// depends on: shc_pkg, shc_hit_ram
//
// Usage:
//   Hits of one event arrive on the s_axis channel, one transfer per hit, and
//   the hit carrying tlast closes the event. Each hit is stored at the next
//   free place of the hit store; hits beyond the store size are dropped and
//   mark the event as overflowed.
//   After the closing hit, s_axis_tready stays low while the stored hits are
//   scanned. Every scanned position takes a read step and a check step on the
//   single store read port, for each seed candidate and each neighbour
//   candidate checked; a growth direction that runs into the end of the store
//   stops at its read step, and each cluster ends with an emit step. A last
//   step at the end of the scan closes the event.
//   Each cluster leaves as one m_axis transfer; the final cluster of the
//   event has tlast set, and tuser carries the overflow mark. A cluster is
//   held back until the next one is found or the scan ends, so the final
//   cluster can be marked. If the receiver stalls, the scan waits at the
//   next cluster until the output register frees up.
//   Configuration writes take effect at once and are meant for idle time.
//   Reset empties the event, clears the output and restores the default step and factors.
module strip_hit_clusterer_unit
    import shc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // hit input: adc_value, hit_threshold, channel, floating_strip, zero fill
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // cluster output: first_index, seed_index, end_index, cluster_number
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    // tuser: overflow
    output logic [0:0]            m_axis_tuser,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // configuration registers
    logic [STEP_W-1:0]   max_step_reg;
    logic [FACTOR_W-1:0] seed_factor_reg;
    logic [FACTOR_W-1:0] nb_factor_reg;

    // control state
    shc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] clus_reg, clus_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic [CNT_W-1:0]        first_reg, first_next;
    logic [CNT_W-1:0]        end_reg, end_next;
    logic [ADC_BITS-1:0]     sthr_reg, sthr_next;
    logic [CHANNEL_BITS-1:0] seed_chan_reg, seed_chan_next;
    logic [CHANNEL_BITS-1:0] prev_chan_reg, prev_chan_next;
    logic [DMAX_W-1:0]       dmax_reg, dmax_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic [OUT_W-1:0]        pend_first_reg, pend_first_next;
    logic [OUT_W-1:0]        pend_seed_reg, pend_seed_next;
    logic [OUT_W-1:0]        pend_end_reg, pend_end_next;
    logic [OUT_W-1:0]        pend_num_reg, pend_num_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_ovf_reg, out_ovf_next;

    // store ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    hit_t             wr_hit;
    hit_t             rd_hit;

    // shared compare logic
    logic                    in_xfer;
    logic                    out_free;
    logic [FACTOR_W-1:0]     cmp_factor;
    logic [ADC_BITS-1:0]     cmp_thr;
    logic                    adc_ok;
    logic                    dist_ok;
    logic [DMAX_W-1:0]       rd_dmax;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg    <= RST_MAX_STEP;
            seed_factor_reg <= RST_SEED_FACTOR;
            nb_factor_reg   <= RST_NB_FACTOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_STEP:    max_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_SEED_FACTOR: seed_factor_reg <= cfg_data[FACTOR_W-1:0];
                CFG_NB_FACTOR:   nb_factor_reg   <= cfg_data[FACTOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // unpack the incoming hit
    assign wr_hit.adc  = s_axis_tdata[ADC_BITS-1:0];
    assign wr_hit.thr  = s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
    assign wr_hit.chan = s_axis_tdata[2*ADC_BITS+CHANNEL_BITS-1:2*ADC_BITS];
    assign wr_hit.flt  = s_axis_tdata[HIT_W-1];

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign ram_we        = in_xfer && (count_reg < CNT_W'(MAX_HITS));

    shc_hit_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_hit),
        .raddr (ram_raddr),
        .rdata (rd_hit)
    );

    // seed test uses the hit's own threshold, neighbours use the seed's
    assign cmp_factor = (state_reg == ST_SEED_CHK) ? seed_factor_reg : nb_factor_reg;
    assign cmp_thr    = (state_reg == ST_SEED_CHK) ? rd_hit.thr : sthr_reg;
    assign adc_ok     = reaches(rd_hit.adc, cmp_factor, cmp_thr);
    assign dist_ok    = LIM_W'(chan_dist(prev_chan_reg, rd_hit.chan)) <= lim_reg;
    assign rd_dmax    = rd_hit.flt ? {max_step_reg, 1'b0} : {1'b0, max_step_reg};

    assign out_free = !out_valid_reg || m_axis_tready;

    // sequencer: load, scan, grow forward and backward, emit
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        s_next          = s_reg;
        pos_next        = pos_reg;
        clus_next       = clus_reg;
        pend_valid_next = pend_valid_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        sthr_next       = sthr_reg;
        seed_chan_next  = seed_chan_reg;
        prev_chan_next  = prev_chan_reg;
        dmax_next       = dmax_reg;
        lim_next        = lim_reg;
        pend_first_next = pend_first_reg;
        pend_seed_next  = pend_seed_reg;
        pend_end_next   = pend_end_reg;
        pend_num_next   = pend_num_reg;
        ram_raddr       = s_reg[IDX_W-1:0];

        // output register drains on a transfer
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        s_next          = '0;
                        clus_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SEED_RD;
                    end
                end
            end

            ST_SEED_RD:
            begin
                ram_raddr = s_reg[IDX_W-1:0];
                if (s_reg == count_reg)
                begin
                    // end of scan: release the held cluster as the final one
                    if (!pend_valid_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = OUT_DATA_W'({pend_num_reg, pend_end_reg,
                                                       pend_seed_reg, pend_first_reg});
                        out_last_next   = 1'b1;
                        out_ovf_next    = ovf_reg;
                        pend_valid_next = 1'b0;
                        count_next      = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
                else
                begin
                    state_next = ST_SEED_CHK;
                end
            end

            ST_SEED_CHK:
            begin
                sthr_next      = rd_hit.thr;
                seed_chan_next = rd_hit.chan;
                prev_chan_next = rd_hit.chan;
                dmax_next      = rd_dmax;
                lim_next       = LIM_W'(rd_dmax);
                if (adc_ok)
                begin
                    pos_next   = s_reg + 1'b1;
                    state_next = ST_FWD_RD;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_SEED_RD;
                end
            end

            ST_FWD_RD:
            begin
                ram_raddr = pos_reg[IDX_W-1:0];
                if (pos_reg == count_reg)
                begin
                    end_next       = pos_reg - 1'b1;
                    pos_next       = s_reg;
                    prev_chan_next = seed_chan_reg;
                    lim_next       = LIM_W'(dmax_reg);
                    state_next     = ST_BWD_RD;
                end
                else
                begin
                    state_next = ST_FWD_CHK;
                end
            end

            ST_FWD_CHK:
            begin
                if (adc_ok && dist_ok)
                begin
                    prev_chan_next = rd_hit.chan;
                    pos_next       = pos_reg + 1'b1;
                    lim_next       = lim_reg + LIM_W'(dmax_reg);
                    state_next     = ST_FWD_RD;
                end
                else
                begin
                    end_next       = pos_reg - 1'b1;
                    pos_next       = s_reg;
                    prev_chan_next = seed_chan_reg;
                    lim_next       = LIM_W'(dmax_reg);
                    state_next     = ST_BWD_RD;
                end
            end

            ST_BWD_RD:
            begin
                ram_raddr = pos_reg[IDX_W-1:0] - 1'b1;
                if (pos_reg == '0)
                begin
                    first_next = pos_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_BWD_CHK;
                end
            end

            ST_BWD_CHK:
            begin
                if (adc_ok && dist_ok)
                begin
                    prev_chan_next = rd_hit.chan;
                    pos_next       = pos_reg - 1'b1;
                    lim_next       = lim_reg + LIM_W'(dmax_reg);
                    state_next     = ST_BWD_RD;
                end
                else
                begin
                    first_next = pos_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // push any held cluster out as non-final, then hold this one
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = OUT_DATA_W'({pend_num_reg, pend_end_reg,
                                                      pend_seed_reg, pend_first_reg});
                        out_last_next  = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_first_next = OUT_W'(first_reg);
                    pend_seed_next  = OUT_W'(s_reg);
                    pend_end_next   = OUT_W'(end_reg);
                    pend_num_next   = OUT_W'(clus_reg);
                    clus_next       = clus_reg + 1'b1;
                    s_next          = end_reg + 1'b1;
                    state_next      = ST_SEED_RD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            s_reg          <= '0;
            pos_reg        <= '0;
            clus_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            s_reg          <= s_next;
            pos_reg        <= pos_next;
            clus_reg       <= clus_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        end_reg        <= end_next;
        sthr_reg       <= sthr_next;
        seed_chan_reg  <= seed_chan_next;
        prev_chan_reg  <= prev_chan_next;
        dmax_reg       <= dmax_next;
        lim_reg        <= lim_next;
        pend_first_reg <= pend_first_next;
        pend_seed_reg  <= pend_seed_next;
        pend_end_reg   <= pend_end_next;
        pend_num_reg   <= pend_num_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // output channel
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_ovf_reg;

endmodule

// File: rtl/shc_checker.sv
// port-level checks for the strip hit clusterer, bound to the top level
// depends on: shc_pkg, strip_hit_clusterer_unit_assert.svh
`include "strip_hit_clusterer_unit_assert.svh"

module shc_checker
    import shc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic [OUT_W-1:0] first_idx;
    logic [OUT_W-1:0] seed_idx;
    logic [OUT_W-1:0] end_idx;

    assign first_idx = m_axis_tdata[OUT_W-1:0];
    assign seed_idx  = m_axis_tdata[2*OUT_W-1:OUT_W];
    assign end_idx   = m_axis_tdata[3*OUT_W-1:2*OUT_W];

    // a stalled cluster holds its payload
    `SHC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled cluster changed")

    // the closing hit stops further loading while the scan runs
    `SHC_ASSERT_NEXT(a_scan_blocks_input, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken right after event close")

    // a non-final cluster is followed by more scanning or by the final cluster
    `SHC_ASSERT_NEXT(a_more_clusters, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready || m_axis_tvalid, "event ended without a final cluster")

    // the seed lies inside its cluster range
    `SHC_ASSERT_NOW(a_seed_in_range, m_axis_tvalid, first_idx <= seed_idx && seed_idx <= end_idx, "seed outside its cluster")

endmodule

bind strip_hit_clusterer_unit shc_checker u_shc_checker (.*);

// File: tb/tb.sv
// self-checking bench for strip_hit_clusterer_unit: streams strip-hit events and
// predicts every cluster transfer in a small scoreboard class
// depends on: shc_pkg and the strip_hit_clusterer_unit rtl
`timescale 1ns / 100ps

module tb;
    import shc_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4 * MAX_HITS + 16;
    localparam int RANDOM_HITS   = 370;
    localparam int CALM_START    = 150;
    localparam int CALM_STOP     = 240;

    // one predicted cluster transfer
    typedef struct packed {
        logic [OUT_W-1:0] first_idx;
        logic [OUT_W-1:0] seed_idx;
        logic [OUT_W-1:0] end_idx;
        logic [OUT_W-1:0] number;
        logic             closing;
        logic             ovf;
    } cluster_t;

    // event store, clustering predictor and queue of clusters still to arrive
    class cluster_book;
        logic [STEP_W-1:0]   step_reg;
        logic [FACTOR_W-1:0] seed_reg;
        logic [FACTOR_W-1:0] nb_reg;
        hit_t                stored [MAX_HITS];
        int                  n_stored;
        bit                  cut;
        cluster_t            pending_clusters [$];
        int                  failures;

        function new();
            step_reg = RST_MAX_STEP;
            seed_reg = RST_SEED_FACTOR;
            nb_reg   = RST_NB_FACTOR;
            n_stored = 0;
            cut      = 0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MAX_STEP:    step_reg = val[STEP_W-1:0];
                CFG_SEED_FACTOR: seed_reg = val[FACTOR_W-1:0];
                CFG_NB_FACTOR:   nb_reg   = val[FACTOR_W-1:0];
                default: ;
            endcase
        endfunction

        // amplitude reaches mult/16 times base
        function bit above(logic [ADC_BITS-1:0] amp, logic [FACTOR_W-1:0] mult,
                           logic [ADC_BITS-1:0] base);
            return int'(amp) * 16 >= int'(mult) * int'(base);
        endfunction

        function int gap(logic [CHANNEL_BITS-1:0] a, logic [CHANNEL_BITS-1:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        // store one accepted hit; on the closing hit, cluster the whole event
        function void note_hit(hit_t h, bit last_hit);
            cluster_t c;
            int pos, s, f, b, dmax, count;
            if (n_stored < MAX_HITS)
            begin
                stored[n_stored] = h;
                n_stored++;
            end
            else
                cut = 1;
            if (!last_hit)
                return;
            count = 0;
            pos   = 0;
            while (pos < n_stored)
            begin
                s = pos;
                if (above(stored[s].adc, seed_reg, stored[s].thr))
                begin
                    dmax = int'(step_reg) * (stored[s].flt ? 2 : 1);
                    // grow forward, distance measured from the previous member
                    f = 1;
                    while (s + f < n_stored
                           && above(stored[s+f].adc, nb_reg, stored[s].thr)
                           && gap(stored[s+f-1].chan, stored[s+f].chan) <= f * dmax)
                        f++;
                    f--;
                    // grow backward, may reach into earlier clusters
                    b = 1;
                    while (b <= s
                           && above(stored[s-b].adc, nb_reg, stored[s].thr)
                           && gap(stored[s-b+1].chan, stored[s-b].chan) <= b * dmax)
                        b++;
                    b--;
                    c.first_idx = OUT_W'(s - b);
                    c.seed_idx  = OUT_W'(s);
                    c.end_idx   = OUT_W'(s + f);
                    c.number    = OUT_W'(count);
                    c.closing   = 1'b0;
                    c.ovf       = cut;
                    pending_clusters.insert(pending_clusters.size(), c);
                    count++;
                    // forward members are not scanned again
                    pos = s + f;
                end
                pos++;
            end
            if (count > 0)
                pending_clusters[pending_clusters.size()-1].closing = 1'b1;
            n_stored = 0;
            cut      = 0;
        endfunction

        // compare one cluster transfer with the oldest prediction
        function void check_cluster(logic [OUT_DATA_W-1:0] data, logic tlast, logic ovf);
            cluster_t got, want;
            got.first_idx = data[0 +: OUT_W];
            got.seed_idx  = data[OUT_W +: OUT_W];
            got.end_idx   = data[2*OUT_W +: OUT_W];
            got.number    = data[3*OUT_W +: OUT_W];
            got.closing   = tlast;
            got.ovf       = ovf;
            if (pending_clusters.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected cluster: first %0d seed %0d end %0d number %0d",
                             got.first_idx, got.seed_idx, got.end_idx, got.number);
                return;
            end
            want = pending_clusters.pop_front();
            if (got.first_idx !== want.first_idx || got.seed_idx !== want.seed_idx
                || got.end_idx !== want.end_idx || got.number !== want.number
                || got.closing !== want.closing || got.ovf !== want.ovf)
            begin
                failures++;
                if (failures <= 10)
                    $display({"cluster mismatch: expected first %0d seed %0d end %0d ",
                              "number %0d last %0b ovf %0b, got %0d %0d %0d %0d %0b %0b"},
                             want.first_idx, want.seed_idx, want.end_idx, want.number,
                             want.closing, want.ovf, got.first_idx, got.seed_idx,
                             got.end_idx, got.number, got.closing, got.ovf);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;

    bit          no_idle = 1'b0;
    int          hits_sent = 0;
    int          stall_cycles = 0;
    cluster_book sb = new();

    strip_hit_clusterer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 21);

    // cluster transfers go to the scoreboard
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_cluster(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic hit_t mk_hit(int adc, int thr, int chan, bit flt);
        hit_t h;
        h.adc  = ADC_BITS'(adc);
        h.thr  = ADC_BITS'(thr);
        h.chan = CHANNEL_BITS'(chan);
        h.flt  = flt;
        return h;
    endfunction

    // one hit transfer, valid held high until accepted
    task automatic send_hit(input hit_t h, input bit last_hit);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(h);
        s_axis_tlast  <= last_hit;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_hit(h, last_hit);
        hits_sent++;
    endtask

    // drain all predicted clusters, then let a cluster-less scan finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_clusters.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers back to back
    task automatic program_regs(input logic [STEP_W-1:0] step,
                                input logic [FACTOR_W-1:0] sf,
                                input logic [FACTOR_W-1:0] nf);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_STEP;
        cfg_data  <= CFG_W'(step);
        sb.set_reg(CFG_MAX_STEP, CFG_W'(step));
        @(posedge clk);
        cfg_index <= CFG_SEED_FACTOR;
        cfg_data  <= CFG_W'(sf);
        sb.set_reg(CFG_SEED_FACTOR, CFG_W'(sf));
        @(posedge clk);
        cfg_index <= CFG_NB_FACTOR;
        cfg_data  <= CFG_W'(nf);
        sb.set_reg(CFG_NB_FACTOR, CFG_W'(nf));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random event: mostly neighbouring channels with amplitudes near threshold, or fully random hits when noisy
    task automatic send_event(input int len, input bit noisy);
        hit_t h;
        logic [CHANNEL_BITS-1:0] ch;
        int amp;
        ch = CHANNEL_BITS'($urandom_range(1023));
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
            begin
                h.adc  = ADC_BITS'($urandom);
                h.thr  = ADC_BITS'($urandom);
                h.chan = CHANNEL_BITS'($urandom);
                h.flt  = 1'($urandom_range(1));
            end
            else
            begin
                h.thr = ($urandom_range(9) == 0) ? ADC_BITS'($urandom_range(4095))
                                                 : ADC_BITS'($urandom_range(200));
                if ($urandom_range(3) == 0)
                    h.adc = ADC_BITS'($urandom);
                else
                begin
                    amp   = int'(h.thr) * int'($urandom_range(64)) / 16;
                    h.adc = (amp > 4095) ? {ADC_BITS{1'b1}} : ADC_BITS'(amp);
                end
                if ($urandom_range(9) == 0)
                    ch = CHANNEL_BITS'($urandom_range(1023));
                else
                    ch = ch + CHANNEL_BITS'($urandom_range(3));
                h.chan = ch;
                h.flt  = ($urandom_range(9) < 3);
            end
            send_hit(h, i == len - 1);
        end
    endtask

    // stimulus
    initial
    begin
        int ev, len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset factors: single seed with extreme fields, then a lone non-seed
        send_hit(mk_hit(4095, 0, 1023, 1), 1);
        send_hit(mk_hit(0, 4095, 0, 0), 1);
        // forward and backward growth, forward skip, zero threshold seed
        send_hit(mk_hit(50, 40, 10, 0), 0);
        send_hit(mk_hit(200, 20, 11, 0), 0);
        send_hit(mk_hit(60, 50, 12, 0), 0);
        send_hit(mk_hit(30, 0, 14, 0), 0);
        send_hit(mk_hit(0, 0, 500, 0), 1);
        // floating seed doubles the allowed distance
        send_hit(mk_hit(100, 10, 100, 1), 0);
        send_hit(mk_hit(100, 100, 102, 0), 1);
        // backward growth overlapping the previous cluster
        send_hit(mk_hit(100, 30, 5, 0), 0);
        send_hit(mk_hit(20, 1, 6, 0), 1);

        // zero step, largest factors
        wait_idle();
        program_regs('0, '1, '1);
        send_hit(mk_hit(4095, 256, 300, 0), 0);
        send_hit(mk_hit(4095, 3000, 300, 1), 0);
        send_hit(mk_hit(4095, 257, 301, 0), 1);

        // widest step, zero factors: every hit qualifies
        wait_idle();
        program_regs('1, '0, '0);
        send_hit(mk_hit(1, 4095, 0, 1), 0);
        send_hit(mk_hit(0, 0, 126, 0), 0);
        send_hit(mk_hit(2048, 1, 378, 1), 0);
        send_hit(mk_hit(7, 9, 900, 0), 1);

        // random phases, new settings every eight events
        hits_sent = 0;
        ev = 0;
        while (hits_sent < RANDOM_HITS)
        begin
            if (ev % 8 == 0)
            begin
                wait_idle();
                program_regs(($urandom_range(4) == 0) ? STEP_W'($urandom_range(63))
                                                      : STEP_W'($urandom_range(3)),
                             ($urandom_range(4) == 0) ? FACTOR_W'($urandom_range(255))
                                                      : FACTOR_W'($urandom_range(64, 16)),
                             ($urandom_range(4) == 0) ? FACTOR_W'($urandom_range(255))
                                                      : FACTOR_W'($urandom_range(32)));
            end
            no_idle <= (hits_sent >= CALM_START && hits_sent < CALM_STOP);
            // one overflowed event, one exactly full, the rest mostly short
            if (ev == 3)
                len = MAX_HITS + 2;
            else if (ev == 11)
                len = MAX_HITS;
            else if ($urandom_range(19) == 0)
                len = $urandom_range(40, 16);
            else
                len = $urandom_range(10, 1);
            send_event(len, $urandom_range(99) < 20);
            ev++;
        end

        wait_idle();
        if (sb.failures == 0 && sb.pending_clusters.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/shc_pkg.sv
rtl/shc_hit_ram.sv
rtl/strip_hit_clusterer_unit.sv
rtl/shc_checker.sv
tb/tb.sv
